// ===== src/grid_fixed_radius_neighbour_finder_assert.svh =====
// Assertion macros for the grid neighbour finder. The module that uses them
// must have clk and rst in scope.
`ifndef GRID_FIXED_RADIUS_NEIGHBOUR_FINDER_ASSERT_SVH
`define GRID_FIXED_RADIUS_NEIGHBOUR_FINDER_ASSERT_SVH

// Same-cycle implication.
`define GFRNF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gfrnf: same-cycle check failed");

// Next-cycle implication.
`define GFRNF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gfrnf: next-cycle check failed");

`endif

// ===== src/gfrnf_pkg.sv =====
// ----------------------------------------------------------------------------
// gfrnf_pkg
// Types and fixed constants shared by the grid neighbour finder modules.
// ----------------------------------------------------------------------------
package gfrnf_pkg;

  localparam int COORD_W      = 16;
  localparam int CFG_W        = 15;
  localparam int IDX_W        = 8;
  localparam int RESULT_LIMIT = 36;
  localparam int CNT_W        = 6;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    KIND_NEAR    = 3'd0,
    KIND_NONE    = 3'd1,
    KIND_BINNED  = 3'd2,
    KIND_OUTSIDE = 3'd3,
    KIND_FULL    = 3'd4
  } kind_t;

  // Classified command: low bits of the bin index and which of the three
  // neighbouring columns and rows lie inside the grid.
  typedef struct packed {
    logic                       func;
    logic signed [COORD_W-1:0]  px;
    logic signed [COORD_W-1:0]  py;
    logic [IDX_W-1:0]           nx;
    logic [IDX_W-1:0]           ny;
    logic [2:0]                 vx;
    logic [2:0]                 vy;
  } cmd_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic                       last;
  } res_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_MUL, F_CHK} fstate_t;

  typedef enum logic [2:0] {
    B_IDLE, B_ASTART, B_AFILL, B_QBIN, B_QFILL, B_QDATA, B_QCMP, B_QEND
  } bstate_t;

endpackage

// ===== src/gfrnf_fifo.sv =====
// ----------------------------------------------------------------------------
// gfrnf_fifo
// Small register queue with full/empty flags; head data is shown directly.
// ----------------------------------------------------------------------------
module gfrnf_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] din,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic          do_push, do_pop;

  assign full    = (cnt == CW'(DEPTH));
  assign empty   = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (do_pop) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= din;
    end
  end

endmodule

// ===== src/gfrnf_div.sv =====
// ----------------------------------------------------------------------------
// gfrnf_div
// Restoring divider: 16-bit magnitude by 15-bit divisor, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module gfrnf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [14:0] divisor,
  output logic [15:0] quot,
  output logic        done
);
  logic        busy;
  logic [3:0]  cnt;
  logic [15:0] rem;
  logic [14:0] dvs;
  logic [15:0] trial;

  assign trial = {rem[14:0], quot[15]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 4'd15);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem  <= trial - {1'b0, dvs};
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[14:0], 1'b0};
      end
    end
  end

endmodule

// ===== src/gfrnf_front.sv =====
// ----------------------------------------------------------------------------
// gfrnf_front
// Accepts items, divides the coordinates by the radius and works out which
// of the surrounding bin columns and rows exist.
// ----------------------------------------------------------------------------
module gfrnf_front #(
  parameter int MAX_XBINS = 16,
  parameter int MAX_YBINS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           func,
  input  logic signed [15:0]             point_x,
  input  logic signed [15:0]             point_y,
  input  logic [14:0]                    radius,
  input  logic [14:0]                    area_width,
  input  logic [14:0]                    area_height,
  output logic                           cmd_push,
  output gfrnf_pkg::cmd_t                cmd,
  input  logic                           cmd_full
);
  import gfrnf_pkg::*;

  fstate_t            state, state_next;
  logic               func_r;
  logic signed [15:0] px, py;
  logic               start;
  logic [15:0]        magx, magy, qx, qy;
  logic               donex, doney;
  logic signed [16:0] nx, ny;
  logic signed [32:0] prodx, prody;

  // Bin column d-1 relative to n exists when it is not negative, below the
  // maximum and its left edge is within the extent.
  function automatic logic [2:0] axis_ok(input logic signed [16:0] n,
                                         input logic signed [32:0] p,
                                         input logic [14:0] rr,
                                         input logic [14:0] ext,
                                         input int maxb);
    logic signed [17:0] ix;
    logic signed [33:0] ixr;
    logic signed [33:0] rs;
    logic [2:0]         ok;
    rs = $signed({19'b0, rr});
    for (int d = 0; d < 3; d++) begin
      ix  = $signed({n[16], n}) + $signed(18'(d)) - 18'sd1;
      ixr = $signed({p[32], p});
      if (d == 0) begin
        ixr = ixr - rs;
      end else if (d == 2) begin
        ixr = ixr + rs;
      end
      ok[d] = !ix[17] && (ix < $signed(18'(maxb))) && (ixr <= $signed({19'b0, ext}));
    end
    return ok;
  endfunction

  assign magx  = point_x[15] ? 16'(-point_x) : point_x;
  assign magy  = point_y[15] ? 16'(-point_y) : point_y;
  assign full  = (state != F_IDLE);
  assign start = (state == F_IDLE) && push;

  gfrnf_div u_divx (
    .clk(clk), .rst(rst), .start(start), .dividend(magx), .divisor(radius),
    .quot(qx), .done(donex)
  );

  gfrnf_div u_divy (
    .clk(clk), .rst(rst), .start(start), .dividend(magy), .divisor(radius),
    .quot(qy), .done(doney)
  );

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (push) state_next = F_DIV;
      F_DIV:   if (donex && doney) state_next = F_MUL;
      F_MUL:   state_next = F_CHK;
      F_CHK:   if (!cmd_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    cmd_push = (state == F_CHK) && !cmd_full;
    cmd.func = func_r;
    cmd.px   = px;
    cmd.py   = py;
    cmd.nx   = nx[IDX_W-1:0];
    cmd.ny   = ny[IDX_W-1:0];
    cmd.vx   = axis_ok(nx, prodx, radius, area_width, MAX_XBINS);
    cmd.vy   = axis_ok(ny, prody, radius, area_height, MAX_YBINS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      func_r <= func;
      px     <= point_x;
      py     <= point_y;
    end
    if (state == F_DIV) begin
      nx <= px[15] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      ny <= py[15] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
    end
    if (state == F_MUL) begin
      prodx <= 33'(nx * $signed({2'b0, radius}));
      prody <= 33'(ny * $signed({2'b0, radius}));
    end
  end

endmodule

// ===== src/gfrnf_back.sv =====
// ----------------------------------------------------------------------------
// gfrnf_back
// Holds the bins. Appends a point, or walks the 3x3 bins around a query
// point and emits stored points within the radius, except the point itself.
// ----------------------------------------------------------------------------
`include "grid_fixed_radius_neighbour_finder_assert.svh"

module gfrnf_back #(
  parameter int MAX_XBINS    = 16,
  parameter int MAX_YBINS    = 16,
  parameter int BIN_CAPACITY = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic [14:0]      radius,
  input  logic             cmd_empty,
  input  gfrnf_pkg::cmd_t  cmd_in,
  output logic             cmd_pop,
  output logic             opush,
  output gfrnf_pkg::res_t  odata,
  input  logic             ofull
);
  import gfrnf_pkg::*;

  localparam int NB = MAX_XBINS * MAX_YBINS;
  localparam int BW = (NB > 1) ? $clog2(NB) : 1;
  localparam int SN = NB * BIN_CAPACITY;
  localparam int SW = (SN > 1) ? $clog2(SN) : 1;
  localparam int FW = $clog2(BIN_CAPACITY + 1);

  bstate_t            state, state_next;
  cmd_t               c;
  logic [1:0]         dxi, dyi;
  logic [FW-1:0]      slot, fcnt;
  logic [CNT_W-1:0]   ncnt;
  logic               pend;
  logic signed [15:0] pend_x, pend_y, cand_x, cand_y;
  logic [31:0]        sqx, sqy;
  logic               same;
  logic [29:0]        r2;

  logic [FW-1:0]      fill_mem [NB];
  logic [31:0]        store [SN];
  logic               vld [NB];
  logic [FW-1:0]      fill_q;
  logic               vld_q;
  logic [FW-1:0]      fill_eff;
  logic [31:0]        sdata;

  logic [IDX_W-1:0]   ix, iy;
  logic [BW-1:0]      bin_a;
  logic [FW-1:0]      st_slot;
  logic [SW-1:0]      st_ra;
  logic               fill_we, st_we, adv, last_bin, hit, more;
  logic signed [16:0] dx, dy;
  logic [15:0]        adx, ady;

  assign ix       = IDX_W'(c.nx + {6'b0, dxi} - 8'd1);
  assign iy       = IDX_W'(c.ny + {6'b0, dyi} - 8'd1);
  assign bin_a    = BW'(({9'b0, ix} * 17'(MAX_YBINS)) + {9'b0, iy});
  assign st_slot  = (state == B_QFILL) ? '0 : slot + FW'(1);
  assign st_ra    = SW'(32'(bin_a) * 32'(BIN_CAPACITY) + 32'(st_slot));
  assign fill_eff = vld_q ? fill_q : '0;
  assign last_bin = (dxi == 2'd2) && (dyi == 2'd2);
  assign hit      = ({1'b0, sqx} + {1'b0, sqy} < {3'b0, r2}) && !same &&
                    (ncnt < CNT_W'(RESULT_LIMIT));
  assign more     = (slot + FW'(1)) < fcnt;

  assign dx  = $signed({sdata[31], sdata[31:16]}) - $signed({c.px[15], c.px});
  assign dy  = $signed({sdata[15], sdata[15:0]}) - $signed({c.py[15], c.py});
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!cmd_empty) begin
          state_next = (cmd_in.func == FUNC_QUERY) ? B_QBIN : B_ASTART;
        end
      end
      B_ASTART: begin
        if (!(c.vx[1] && c.vy[1])) begin
          if (!ofull) state_next = B_IDLE;
        end else begin
          state_next = B_AFILL;
        end
      end
      B_AFILL: if (!ofull) state_next = B_IDLE;
      B_QBIN: begin
        if (c.vx[dxi] && c.vy[dyi]) state_next = B_QFILL;
        else if (last_bin) state_next = B_QEND;
      end
      B_QFILL: begin
        if (fill_eff != '0) state_next = B_QDATA;
        else if (last_bin) state_next = B_QEND;
        else state_next = B_QBIN;
      end
      B_QDATA: state_next = B_QCMP;
      B_QCMP: begin
        if (!(hit && pend && ofull)) begin
          if (more) state_next = B_QDATA;
          else if (last_bin) state_next = B_QEND;
          else state_next = B_QBIN;
        end
      end
      B_QEND:  if (!ofull) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    opush   = 1'b0;
    odata   = '{kind: KIND_NONE, x: '0, y: '0, last: 1'b1};
    fill_we = 1'b0;
    st_we   = 1'b0;
    adv     = 1'b0;
    case (state)
      B_IDLE: cmd_pop = !cmd_empty;
      B_ASTART: begin
        if (!(c.vx[1] && c.vy[1])) begin
          opush      = !ofull;
          odata.kind = KIND_OUTSIDE;
        end
      end
      B_AFILL: begin
        opush = !ofull;
        if (fill_eff >= FW'(BIN_CAPACITY)) begin
          odata.kind = KIND_FULL;
        end else begin
          odata.kind = KIND_BINNED;
          fill_we    = !ofull;
          st_we      = !ofull;
        end
      end
      B_QBIN:  adv = !(c.vx[dxi] && c.vy[dyi]);
      B_QFILL: adv = (fill_eff == '0);
      B_QCMP: begin
        if (!(hit && pend && ofull)) begin
          opush = hit && pend;
          adv   = !more;
        end
        odata = '{kind: KIND_NEAR, x: pend_x, y: pend_y, last: 1'b0};
      end
      B_QEND: begin
        opush = !ofull;
        if (pend) begin
          odata = '{kind: KIND_NEAR, x: pend_x, y: pend_y, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill counts read as zero until the bin is first written after a clear.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      for (int i = 0; i < NB; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (fill_we) begin
      vld[bin_a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q  <= vld[bin_a];
    fill_q <= fill_mem[bin_a];
    if (fill_we) begin
      fill_mem[bin_a] <= fill_eff + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    sdata <= store[st_ra];
    if (st_we) begin
      store[SW'(32'(bin_a) * 32'(BIN_CAPACITY) + 32'(fill_eff))] <= {c.px, c.py};
    end
  end

  always_ff @(posedge clk) begin
    r2 <= 30'(radius * radius);
    if (cmd_pop) begin
      c    <= cmd_in;
      dxi  <= (cmd_in.func == FUNC_QUERY) ? 2'd0 : 2'd1;
      dyi  <= (cmd_in.func == FUNC_QUERY) ? 2'd0 : 2'd1;
      ncnt <= '0;
      pend <= 1'b0;
    end
    if (adv) begin
      if (dyi == 2'd2) begin
        dyi <= 2'd0;
        dxi <= dxi + 2'd1;
      end else begin
        dyi <= dyi + 2'd1;
      end
    end
    if (state == B_QFILL) begin
      slot <= '0;
      fcnt <= fill_eff;
    end
    if (state == B_QDATA) begin
      sqx    <= 32'(adx) * 32'(adx);
      sqy    <= 32'(ady) * 32'(ady);
      same   <= (sdata == {c.px, c.py});
      cand_x <= sdata[31:16];
      cand_y <= sdata[15:0];
    end
    if (state == B_QCMP && !(hit && pend && ofull)) begin
      if (hit) begin
        pend   <= 1'b1;
        pend_x <= cand_x;
        pend_y <= cand_y;
        ncnt   <= ncnt + CNT_W'(1);
      end
      if (more) begin
        slot <= slot + FW'(1);
      end
    end
  end

  `GFRNF_ASSERT_IMP(a_no_overflow, opush, !ofull)
  `GFRNF_ASSERT_IMP(a_fill_in_range, state == B_QFILL, fill_eff <= FW'(BIN_CAPACITY))
  `GFRNF_ASSERT_NEXT(a_append_done, state == B_AFILL && !ofull, state == B_IDLE)

endmodule

// ===== src/grid_fixed_radius_neighbour_finder.sv =====
// ----------------------------------------------------------------------------
// grid_fixed_radius_neighbour_finder
// Fixed-radius neighbour search over a uniform grid of square bins.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake        Beat
// input     in         push / full      func, point_x, point_y
// result    out        pop / empty      kind, near_x, near_y, last
// config    in         wr_en            wr_index, wr_data
//
// The front holds one item at a time, through two 16-step serial dividers.
// An append runs B_ASTART, then B_AFILL unless it lies outside the grid.
// A query steps through B_QBIN per bin, B_QFILL per existing bin, and
// B_QDATA and B_QCMP per stored point, and ends in B_QEND.
// Reset is synchronous; it clears all bins and restores the register defaults.
// A full result queue stalls the back; a full command queue stalls the front.
// ----------------------------------------------------------------------------
module grid_fixed_radius_neighbour_finder #(
  parameter int MAX_XBINS    = 16,
  parameter int MAX_YBINS    = 16,
  parameter int BIN_CAPACITY = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               func,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         kind,
  output logic signed [15:0] near_x,
  output logic signed [15:0] near_y,
  output logic               last,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [14:0]        wr_data
);
  import gfrnf_pkg::*;

  logic [CFG_W-1:0] area_width, area_height, search_radius, radius;
  logic             clr;
  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t             cmd_f, cmd_b;
  logic             opush, ofull;
  res_t             odata, res;

  assign radius = (search_radius == '0) ? CFG_W'(1) : search_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width    <= CFG_W'(4096);
      area_height   <= CFG_W'(4096);
      search_radius <= CFG_W'(256);
      clr           <= 1'b0;
    end else begin
      clr <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          REG_WIDTH: begin
            area_width <= wr_data;
            clr        <= 1'b1;
          end
          REG_HEIGHT: begin
            area_height <= wr_data;
            clr         <= 1'b1;
          end
          REG_RADIUS: begin
            search_radius <= wr_data;
            clr           <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  gfrnf_front #(.MAX_XBINS(MAX_XBINS), .MAX_YBINS(MAX_YBINS)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .point_x(point_x), .point_y(point_y), .radius(radius),
    .area_width(area_width), .area_height(area_height),
    .cmd_push(cmd_push), .cmd(cmd_f), .cmd_full(cmd_full)
  );

  gfrnf_fifo #(.DW($bits(cmd_t)), .DEPTH(2)) u_cmdq (
    .clk(clk), .rst(rst), .push(cmd_push), .din(cmd_f), .full(cmd_full),
    .pop(cmd_pop), .dout(cmd_b), .empty(cmd_empty)
  );

  gfrnf_back #(
    .MAX_XBINS(MAX_XBINS), .MAX_YBINS(MAX_YBINS), .BIN_CAPACITY(BIN_CAPACITY)
  ) u_back (
    .clk(clk), .rst(rst), .clr(clr), .radius(radius),
    .cmd_empty(cmd_empty), .cmd_in(cmd_b), .cmd_pop(cmd_pop),
    .opush(opush), .odata(odata), .ofull(ofull)
  );

  gfrnf_fifo #(.DW($bits(res_t)), .DEPTH(4)) u_resq (
    .clk(clk), .rst(rst), .push(opush), .din(odata), .full(ofull),
    .pop(pop), .dout(res), .empty(empty)
  );

  assign kind   = res.kind;
  assign near_x = res.x;
  assign near_y = res.y;
  assign last   = res.last;

endmodule

// ===== sim/grid_fixed_radius_neighbour_finder_tb.sv =====
// ----------------------------------------------------------------------------
// grid_fixed_radius_neighbour_finder_tb
// Drives appends and queries through several grid geometries and checks every
// result beat against an in-bench model of the binned point store.
// ----------------------------------------------------------------------------
module grid_fixed_radius_neighbour_finder_tb;
  import gfrnf_pkg::*;

  localparam int XBINS = 16;
  localparam int YBINS = 16;
  localparam int CAP = 4;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    logic  f;
    int    x;
    int    y;
    bit    typed;
    kind_t k;
  } stim_row_t;

  logic clk, rst, push, full, func, empty, pop, last, wr_en;
  logic signed [15:0] point_x, point_y, near_x, near_y;
  logic [2:0] kind;
  logic [1:0] wr_index;
  logic [14:0] wr_data;

  grid_fixed_radius_neighbour_finder u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .func(func),
    .point_x(point_x), .point_y(point_y), .empty(empty), .pop(pop),
    .kind(kind), .near_x(near_x), .near_y(near_y), .last(last),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Model of the grid.
  int area_w, area_h, radius;
  int bin_fill [XBINS*YBINS];
  logic signed [15:0] slot_x [XBINS*YBINS*CAP];
  logic signed [15:0] slot_y [XBINS*YBINS*CAP];
  res_t step_q[$];
  res_t expected_q[$];
  int stored_x[$], stored_y[$];

  int errors = 0;
  int cycles = 0;
  bit quiet = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int eff_radius();
    return (radius == 0) ? 1 : radius;
  endfunction

  function automatic int bin_span(int extent, int maxbins);
    int n;
    n = extent / eff_radius() + 1;
    return (n > maxbins) ? maxbins : n;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void add_result(kind_t k, int x, int y, logic l);
    res_t e;
    e.kind = k;
    e.x = x[15:0];
    e.y = y[15:0];
    e.last = l;
    step_q.push_back(e);
  endfunction

  // Fills step_q with the results of one command and updates the bins.
  function automatic void grid_step(logic f, int px, int py);
    int r, xb, yb, nx, ny, b, s, n;
    longint r2, dx, dy;
    step_q.delete();
    r = eff_radius();
    xb = bin_span(area_w, XBINS);
    yb = bin_span(area_h, YBINS);
    nx = px / r;
    ny = py / r;
    n = 0;
    if (f == FUNC_APPEND) begin
      if (nx < 0 || ny < 0 || nx >= xb || ny >= yb) begin
        add_result(KIND_OUTSIDE, 0, 0, 1'b1);
      end else begin
        b = nx * YBINS + ny;
        if (bin_fill[b] >= CAP) begin
          add_result(KIND_FULL, 0, 0, 1'b1);
        end else begin
          s = b * CAP + bin_fill[b];
          slot_x[s] = px[15:0];
          slot_y[s] = py[15:0];
          bin_fill[b]++;
          add_result(KIND_BINNED, 0, 0, 1'b1);
        end
      end
      return;
    end
    r2 = longint'(r) * r;
    for (int ix = nx - 1; ix <= nx + 1; ix++) begin
      if (ix < 0 || ix >= xb) continue;
      for (int iy = ny - 1; iy <= ny + 1; iy++) begin
        if (iy < 0 || iy >= yb) continue;
        b = ix * YBINS + iy;
        for (int i = 0; i < bin_fill[b]; i++) begin
          s = b * CAP + i;
          dx = longint'(slot_x[s]) - px;
          dy = longint'(slot_y[s]) - py;
          if (dx * dx + dy * dy < r2 && (slot_x[s] != px || slot_y[s] != py)
              && n < RESULT_LIMIT) begin
            add_result(KIND_NEAR, slot_x[s], slot_y[s], 1'b0);
            n++;
          end
        end
      end
    end
    if (n == 0) add_result(KIND_NONE, 0, 0, 1'b1);
    else step_q[n-1].last = 1'b1;
  endfunction

  task automatic send_item(logic f, int x, int y, bit typed, kind_t k);
    res_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      push = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    push = 1'b1;
    func = f;
    point_x = x[15:0];
    point_y = y[15:0];
    do @(posedge clk); while (full);
    grid_step(f, x, y);
    if (typed) begin
      e.kind = k;
      e.x = '0;
      e.y = '0;
      e.last = 1'b1;
      expected_q.push_back(e);
    end else begin
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    end
    if (f == FUNC_APPEND) begin
      stored_x.push_back(x);
      stored_y.push_back(y);
    end
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int value);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = value[14:0];
    @(negedge clk);
    wr_en = 1'b0;
    case (idx)
      REG_WIDTH:  area_w = value;
      REG_HEIGHT: area_h = value;
      default:    radius = value;
    endcase
    foreach (bin_fill[i]) bin_fill[i] = 0;
    stored_x.delete();
    stored_y.delete();
  endtask

  task automatic set_geometry(int w, int h, int r);
    wait_drained();
    // Queries that find nothing still keep the back end busy for a while.
    repeat (100) @(negedge clk);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_RADIUS, r);
  endtask

  function automatic int grid_coord(int extent);
    int r, lo, hi;
    if ($urandom_range(0, 99) < 15) return $signed(16'($urandom));
    r = eff_radius();
    lo = clamp16(-r);
    hi = clamp16(extent + r);
    return lo + $urandom_range(0, hi - lo);
  endfunction

  task automatic random_phase(int count, int pause_at, bit quiet_tail);
    int x, y, j, r;
    logic f;
    r = eff_radius();
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) wait_drained();
      if (quiet_tail && n >= count - 15) quiet = 1;
      f = ($urandom_range(0, 99) < 40) ? FUNC_QUERY : FUNC_APPEND;
      if (f == FUNC_QUERY && stored_x.size() != 0 && $urandom_range(0, 4) != 0) begin
        j = $urandom_range(0, stored_x.size() - 1);
        x = clamp16(stored_x[j] + $signed($urandom_range(0, 2 * r)) - r);
        y = clamp16(stored_y[j] + $signed($urandom_range(0, 2 * r)) - r);
        if ($urandom_range(0, 5) == 0) begin
          x = stored_x[j];
          y = stored_y[j];
        end
      end else begin
        x = grid_coord(area_w);
        y = grid_coord(area_h);
      end
      send_item(f, x, y, 1'b0, KIND_NEAR);
    end
  endtask

  // Result side: random pop bursts, one long hold-off, and the checks.
  initial begin
    int idle_left, hold_left, accepted;
    res_t e;
    idle_left = 0;
    hold_left = 0;
    accepted = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (accepted == 30) begin
        hold_left = 400;
        accepted++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        pop = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        idle_left = $urandom_range(0, 12);
        pop = 1'b0;
      end else begin
        pop = 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        if (accepted < 30) accepted++;
        if (expected_q.size() == 0) begin
          report("unexpected beat kind", kind, -1);
        end else begin
          e = expected_q.pop_front();
          if (kind != e.kind) report("kind", kind, e.kind);
          if (near_x != e.x) report("near_x", near_x, e.x);
          if (near_y != e.y) report("near_y", near_y, e.y);
          if (last != e.last) report("last", last, e.last);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  stim_row_t directed [14];

  initial begin
    rst = 1'b1;
    push = 1'b0;
    func = FUNC_APPEND;
    point_x = '0;
    point_y = '0;
    wr_en = 1'b0;
    wr_index = REG_WIDTH;
    wr_data = '0;
    area_w = 4096;
    area_h = 4096;
    radius = 256;
    foreach (bin_fill[i]) bin_fill[i] = 0;
    directed = '{
      '{FUNC_QUERY,  0,      0,      1, KIND_NONE},
      '{FUNC_APPEND, 0,      0,      1, KIND_BINNED},
      '{FUNC_APPEND, -1,     -1,     1, KIND_BINNED},   // truncates into bin 0
      '{FUNC_APPEND, -256,   0,      1, KIND_OUTSIDE},
      '{FUNC_APPEND, 32767,  32767,  1, KIND_OUTSIDE},
      '{FUNC_APPEND, -32768, -32768, 1, KIND_OUTSIDE},
      '{FUNC_APPEND, 10,     10,     1, KIND_BINNED},
      '{FUNC_APPEND, 20,     20,     1, KIND_BINNED},
      '{FUNC_APPEND, 5,      5,      1, KIND_FULL},
      '{FUNC_QUERY,  0,      0,      0, KIND_NEAR},
      '{FUNC_QUERY,  100,    100,    0, KIND_NEAR},
      '{FUNC_APPEND, 4095,   4095,   1, KIND_BINNED},
      '{FUNC_QUERY,  4000,   4000,   0, KIND_NEAR},
      '{FUNC_QUERY,  -32768, 32767,  1, KIND_NONE}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (directed[i])
      send_item(directed[i].f, directed[i].x, directed[i].y, directed[i].typed,
                directed[i].k);
    random_phase(16, -1, 0);
    // A zero radius behaves as one; with zero width and height a single bin is left.
    set_geometry(0, 0, 0);
    random_phase(10, -1, 0);
    set_geometry(1000, 600, 64);
    random_phase(20, 10, 0);
    set_geometry(32767, 32767, 32767);
    random_phase(12, -1, 0);
    set_geometry(300, 300, 100);
    random_phase(18, -1, 0);
    set_geometry(32767, 32767, 2048);
    random_phase(20, -1, 1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
